/* rtl/segment_circle_hit_select_top_macros.svh */
// Assertion macros shared by the hit select block.
`ifndef SEGMENT_CIRCLE_HIT_SELECT_TOP_MACROS_SVH
`define SEGMENT_CIRCLE_HIT_SELECT_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define SCHS_ASSERT_IMPL(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("schs assertion failed");
`define SCHS_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("schs assertion failed");
`else
`define SCHS_ASSERT_IMPL(lbl, ck, rs, ante, cons)
`define SCHS_ASSERT_NEXT(lbl, ck, rs, ante, cons)
`endif
`endif

/* rtl/schs_pkg.sv */
// ----------------------------------------------------------------------------
// schs_pkg
// Types and constants of the segment circle hit select block.
// ----------------------------------------------------------------------------
package schs_pkg;
  localparam int FRACTION_BITS = 16;
  localparam int CNT_W = $clog2(FRACTION_BITS);
  localparam int COORD_W = 24;
  localparam int DELTA_W = COORD_W + 1;
  localparam int MUL_W = COORD_W + 2;
  localparam int PROD_W = 2 * MUL_W;
  localparam int ACC_W = PROD_W + 1;
  localparam int FRAC_W = FRACTION_BITS + 1;
  localparam int RADIUS_W = 16;
  localparam int ID_W = 12;

  typedef struct packed {
    logic signed [DELTA_W-1:0] dx;
    logic signed [DELTA_W-1:0] dy;
    logic signed [DELTA_W-1:0] px;
    logic signed [DELTA_W-1:0] py;
    logic [RADIUS_W-1:0] radius;
    logic [ID_W-1:0] id;
    logic excluded;
    logic last;
  } entry_t;

  // Queue head as seen by the back end.
  typedef struct packed {
    logic valid;
    entry_t entry;
  } queue_head_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_M0, ST_M1, ST_M2, ST_M3, ST_CLS, ST_DIV,
    ST_OFFX, ST_OFFY, ST_SQX, ST_SQY, ST_DONE
  } state_t;
endpackage

/* rtl/schs_item_if.sv */
// ----------------------------------------------------------------------------
// schs_item_if
// Input channel: one segment and one candidate circle per transfer.
// ----------------------------------------------------------------------------
interface schs_item_if;
  logic valid;
  logic ready;
  logic signed [23:0] seg_start_x;
  logic signed [23:0] seg_start_y;
  logic signed [23:0] seg_end_x;
  logic signed [23:0] seg_end_y;
  logic signed [23:0] target_x;
  logic signed [23:0] target_y;
  logic [15:0] target_radius;
  logic [11:0] target_id;
  logic target_excluded;
  logic last_target;
  modport source (output valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
                  target_x, target_y, target_radius, target_id, target_excluded,
                  last_target, input ready);
  modport sink (input valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
                target_x, target_y, target_radius, target_id, target_excluded,
                last_target, output ready);
endinterface

/* rtl/schs_result_if.sv */
// ----------------------------------------------------------------------------
// schs_result_if
// Result channel: hit flag and winning index per transfer.
// ----------------------------------------------------------------------------
interface schs_result_if;
  logic valid;
  logic ready;
  logic hit_found;
  logic [11:0] hit_id;
  modport source (output valid, hit_found, hit_id, input ready);
  modport sink (input valid, hit_found, hit_id, output ready);
endinterface

/* rtl/schs_front.sv */
// ----------------------------------------------------------------------------
// schs_front
// Accepts items, forms the deltas and the skip flag, and holds a two-entry queue.
// ----------------------------------------------------------------------------
module schs_front (
  input  logic clk,
  input  logic rst,
  schs_item_if.sink item_in,
  output schs_pkg::queue_head_t head,
  input  logic pop
);
  import schs_pkg::*;

  entry_t slots [2];
  logic wr_ptr;
  logic rd_ptr;
  logic [1:0] count;
  entry_t incoming;
  logic push;

  function automatic logic signed [DELTA_W-1:0] diff(input logic signed [COORD_W-1:0] a,
                                                     input logic signed [COORD_W-1:0] b);
    diff = DELTA_W'(a) - DELTA_W'(b);
  endfunction

  always_comb begin
    incoming.dx = diff(item_in.seg_end_x, item_in.seg_start_x);
    incoming.dy = diff(item_in.seg_end_y, item_in.seg_start_y);
    incoming.px = diff(item_in.target_x, item_in.seg_start_x);
    incoming.py = diff(item_in.target_y, item_in.seg_start_y);
    incoming.radius = item_in.target_radius;
    incoming.id = item_in.target_id;
    incoming.excluded = item_in.target_excluded;
    incoming.last = item_in.last_target;
  end

  assign item_in.ready = (count != 2'd2);
  assign push = item_in.valid && item_in.ready;
  assign head.valid = (count != 2'd0);
  assign head.entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end
endmodule

/* rtl/schs_back.sv */
// ----------------------------------------------------------------------------
// schs_back
// Projection, distance test and best-hit selection; r*r aside, one shared multiplier.
// ----------------------------------------------------------------------------
module schs_back (
  input  logic clk,
  input  logic rst,
  input  schs_pkg::queue_head_t head,
  output logic pop,
  schs_result_if.source result_out
);
  import schs_pkg::*;

  localparam logic [FRAC_W-1:0] T_ONE = FRAC_W'(1) << FRACTION_BITS;
  localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) << (FRACTION_BITS - 1);

  state_t state, state_next;
  entry_t e, e_next;
  logic signed [ACC_W-1:0] len_sq, len_sq_next, dot, dot_next;
  logic [ACC_W-1:0] rem, rem_next, dist_sq, dist_sq_next;
  logic [FRAC_W-1:0] t, t_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic signed [MUL_W-1:0] rx, rx_next, ry, ry_next;
  logic best_valid, best_valid_next;
  logic [RADIUS_W-1:0] best_radius, best_radius_next;
  logic [FRAC_W-1:0] best_fraction, best_fraction_next;
  logic [ID_W-1:0] best_id, best_id_next;
  logic out_valid, out_valid_next, out_hit, out_hit_next;
  logic [ID_W-1:0] out_id, out_id_next;

  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0] prod, rounded;
  logic signed [MUL_W-1:0] offset, px_w, py_w;
  logic [ACC_W-1:0] rem2;
  logic [2*RADIUS_W-1:0] rad_sq;
  logic hit, win;

  assign prod = mul_a * mul_b;
  // Rounding half up, then an arithmetic shift, gives floor of the biased value
  // for both signs.
  assign rounded = (prod + HALF) >>> FRACTION_BITS;
  assign offset = rounded[MUL_W-1:0];
  assign px_w = MUL_W'(e.px);
  assign py_w = MUL_W'(e.py);
  assign rem2 = rem << 1;
  assign rad_sq = e.radius * e.radius;
  assign hit = !e.excluded && (dist_sq <= ACC_W'(rad_sq));
  assign win = hit && (!best_valid || e.radius < best_radius ||
                       (e.radius == best_radius && t < best_fraction));

  assign result_out.valid = out_valid;
  assign result_out.hit_found = out_hit;
  assign result_out.hit_id = out_id;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    e_next = e;
    len_sq_next = len_sq;
    dot_next = dot;
    rem_next = rem;
    dist_sq_next = dist_sq;
    t_next = t;
    cnt_next = cnt;
    rx_next = rx;
    ry_next = ry;
    best_valid_next = best_valid;
    best_radius_next = best_radius;
    best_fraction_next = best_fraction;
    best_id_next = best_id;
    out_valid_next = out_valid && !result_out.ready;
    out_hit_next = out_hit;
    out_id_next = out_id;
    mul_a = MUL_W'(e.dx);
    mul_b = MUL_W'(e.dx);
    pop = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (head.valid) begin
          pop = 1'b1;
          e_next = head.entry;
          state_next = head.entry.excluded ? ST_DONE : ST_M0;
        end
      end
      ST_M0: begin
        len_sq_next = ACC_W'(prod);
        state_next = ST_M1;
      end
      ST_M1: begin
        mul_a = MUL_W'(e.dy);
        mul_b = MUL_W'(e.dy);
        len_sq_next = len_sq + ACC_W'(prod);
        state_next = ST_M2;
      end
      ST_M2: begin
        mul_a = px_w;
        dot_next = ACC_W'(prod);
        state_next = ST_M3;
      end
      ST_M3: begin
        mul_a = py_w;
        mul_b = MUL_W'(e.dy);
        dot_next = dot + ACC_W'(prod);
        state_next = ST_CLS;
      end
      ST_CLS: begin
        t_next = '0;
        cnt_next = '0;
        rem_next = ACC_W'(dot);
        if (len_sq == '0 || dot <= 0) begin
          state_next = ST_OFFX;
        end else if (dot >= len_sq) begin
          t_next = T_ONE;
          state_next = ST_OFFX;
        end else begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (rem2 >= ACC_W'(len_sq)) begin
          rem_next = rem2 - ACC_W'(len_sq);
          t_next = {t[FRAC_W-2:0], 1'b1};
        end else begin
          rem_next = rem2;
          t_next = {t[FRAC_W-2:0], 1'b0};
        end
        cnt_next = cnt + CNT_W'(1);
        if (cnt == CNT_W'(FRACTION_BITS - 1)) state_next = ST_OFFX;
      end
      ST_OFFX: begin
        mul_b = MUL_W'(t);
        rx_next = px_w - offset;
        state_next = ST_OFFY;
      end
      ST_OFFY: begin
        mul_a = MUL_W'(e.dy);
        mul_b = MUL_W'(t);
        ry_next = py_w - offset;
        state_next = ST_SQX;
      end
      ST_SQX: begin
        mul_a = rx;
        mul_b = rx;
        dist_sq_next = ACC_W'(prod);
        state_next = ST_SQY;
      end
      ST_SQY: begin
        mul_a = ry;
        mul_b = ry;
        dist_sq_next = dist_sq + ACC_W'(prod);
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!e.last) begin
          if (win) begin
            best_valid_next = 1'b1;
            best_radius_next = e.radius;
            best_fraction_next = t;
            best_id_next = e.id;
          end
          state_next = ST_IDLE;
        end else if (!out_valid || result_out.ready) begin
          out_valid_next = 1'b1;
          out_hit_next = win || best_valid;
          out_id_next = win ? e.id : (best_valid ? best_id : '0);
          best_valid_next = 1'b0;
          best_radius_next = '0;
          best_fraction_next = '0;
          best_id_next = '0;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    e <= e_next;
    len_sq <= len_sq_next;
    dot <= dot_next;
    rem <= rem_next;
    dist_sq <= dist_sq_next;
    t <= t_next;
    cnt <= cnt_next;
    rx <= rx_next;
    ry <= ry_next;
    out_hit <= out_hit_next;
    out_id <= out_id_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_valid <= 1'b0;
      best_radius <= '0;
      best_fraction <= '0;
      best_id <= '0;
      out_valid <= 1'b0;
    end else begin
      best_valid <= best_valid_next;
      best_radius <= best_radius_next;
      best_fraction <= best_fraction_next;
      best_id <= best_id_next;
      out_valid <= out_valid_next;
    end
  end
endmodule

/* rtl/segment_circle_hit_select_top.sv */
// ----------------------------------------------------------------------------
// segment_circle_hit_select_top
// Smallest-radius circle hit by a segment, ties to the lower clamped fraction.
// ----------------------------------------------------------------------------
// Channel     Dir   Payload
// item_in     in    segment, circle centre, radius, id, excluded, last
// result_out  out   hit_found, hit_id (one transfer per last candidate)
//
// An excluded candidate goes from idle straight to the done state in the back end;
// a tested one runs the shared multiplier sequence, plus the divider at one bit per
// cycle when t falls strictly inside the segment.
// The front queue holds two candidates so input transfers continue meanwhile.
// Reset clears the queue, the kept best and the result valid flag.
// A stalled result holds the back end only on a candidate marked last.
module segment_circle_hit_select_top (
  input logic clk,
  input logic rst,
  schs_item_if.sink item_in,
  schs_result_if.source result_out
);
  import schs_pkg::*;

  queue_head_t head;
  logic pop;

  schs_front u_front (
    .clk(clk), .rst(rst), .item_in(item_in), .head(head), .pop(pop)
  );

  schs_back u_back (
    .clk(clk), .rst(rst), .head(head), .pop(pop), .result_out(result_out)
  );

`include "segment_circle_hit_select_top_macros.svh"
  `SCHS_ASSERT_IMPL(a_pop_valid, clk, rst, pop, head.valid)
  `SCHS_ASSERT_IMPL(a_nohit_id, clk, rst, result_out.valid && !result_out.hit_found,
                    result_out.hit_id == 12'd0)
  `SCHS_ASSERT_NEXT(a_pop_then_busy, clk, rst, pop, !pop)
endmodule
